FILE: sv/scs_pkg.sv
package scs_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_ADDR_BITS   = 32;

  localparam int ADDR_W  = 32;
  localparam int DEPTH_W = 7;

  localparam logic [ADDR_W-1:0] CODE_START_RST = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] CODE_END_RST   = 32'h0080_0000;
  localparam logic [1:0]        ALIGN_MASK     = 2'b11;

  localparam logic REG_CODE_START = 1'b0;
  localparam logic REG_CODE_END   = 1'b1;

  localparam logic ACT_CALL = 1'b0;
  localparam logic ACT_RET  = 1'b1;

  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_BAD_CALL = 2'd1;
  localparam logic [1:0] ST_BAD_RET  = 2'd2;

  localparam logic [1:0] CA_NONE      = 2'd0;
  localparam logic [1:0] CA_REGION    = 2'd1;
  localparam logic [1:0] CA_MISMATCH  = 2'd2;
  localparam logic [1:0] CA_UNALIGNED = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] cause;
  } verdict_t;

endpackage

FILE: sv/scs_ram.sv
module scs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/scs_check.sv
module scs_check #(
  parameter int AW = 32
) (
  input  logic              is_ret,
  input  logic [AW-1:0]     addr,
  input  logic [AW-1:0]     expected,
  input  logic [AW-1:0]     code_start,
  input  logic [AW-1:0]     code_end,
  output scs_pkg::verdict_t verdict
);

  import scs_pkg::*;

  logic in_region;
  logic mismatch;
  logic unaligned;
  logic [1:0] bad_status;

  assign in_region  = (addr >= code_start) && (addr <= code_end);
  assign mismatch   = is_ret && (expected != '0) && (addr != expected);
  assign unaligned  = (addr[1:0] & ALIGN_MASK) != 2'b00;
  assign bad_status = is_ret ? ST_BAD_RET : ST_BAD_CALL;

  always_comb begin
    priority if (!in_region) begin
      verdict.status = bad_status;
      verdict.cause  = CA_REGION;
    end else if (mismatch) begin
      verdict.status = bad_status;
      verdict.cause  = CA_MISMATCH;
    end else if (unaligned) begin
      verdict.status = bad_status;
      verdict.cause  = CA_UNALIGNED;
    end else begin
      verdict.status = ST_VALID;
      verdict.cause  = CA_NONE;
    end
  end

endmodule

FILE: sv/shadow_call_stack_checker_top.sv
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  in_action, in_target_addr, in_ret_addr
// out      output     out_valid/out_stall out_status, out_cause, out_stack_full, out_depth
// cfg      input      cfg_we             cfg_index, cfg_wdata
//
// a call beat: check and push happen at accept, result registered
// a return beat is checked after the registered read of the stack ram, result registered
// reset clears depth and handshake, loads region defaults; stack entries are not cleared
// input is stalled while a return waits on its ram read or the output beat is held
module shadow_call_stack_checker_top #(
  parameter int STACK_DEPTH = scs_pkg::DEF_STACK_DEPTH,
  parameter int ADDR_BITS   = scs_pkg::DEF_ADDR_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [scs_pkg::ADDR_W-1:0]  in_target_addr,
  input  logic [scs_pkg::ADDR_W-1:0]  in_ret_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [1:0]                  out_cause,
  output logic                        out_stack_full,
  output logic [scs_pkg::DEPTH_W-1:0] out_depth,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [scs_pkg::ADDR_W-1:0]  cfg_wdata
);

  import scs_pkg::*;

  localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int IW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);

  logic [ADDR_W-1:0] code_start_r;
  logic [ADDR_W-1:0] code_end_r;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic              busy_r;
  logic              empty_r;
  logic [AW-1:0]     ret_addr_r;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_cause_r;
  logic              out_full_r;
  logic [DEPTH_W-1:0] out_depth_r;

  logic              accept;
  logic              is_call;
  logic              is_ret;
  logic              out_free;
  logic              push;
  logic              call_full;
  logic [AW-1:0]     rd_data;
  logic [AW-1:0]     expected;
  logic [AW-1:0]     chk_addr;
  verdict_t          verdict;
  logic [DW+DEPTH_W-1:0] depth_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy_r || !out_free;
  assign accept   = in_valid && !in_stall;
  assign is_call  = accept && (in_action == ACT_CALL);
  assign is_ret   = accept && (in_action == ACT_RET);

  // one checker serves the call at accept and the return in the cycle after its accept
  assign chk_addr = busy_r ? ret_addr_r : in_target_addr[AW-1:0];
  assign expected = (busy_r && !empty_r) ? rd_data : '0;

  scs_check #(.AW(AW)) u_check (
    .is_ret     (busy_r),
    .addr       (chk_addr),
    .expected   (expected),
    .code_start (code_start_r[AW-1:0]),
    .code_end   (code_end_r[AW-1:0]),
    .verdict    (verdict)
  );

  assign push      = is_call && (verdict.cause == CA_NONE) && (depth_r < FULL_DEPTH);
  assign call_full = is_call && (verdict.cause == CA_NONE) && (depth_r == FULL_DEPTH);

  scs_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (depth_r[IW-1:0]),
    .wdata (in_ret_addr[AW-1:0]),
    .re    (is_ret && (depth_r != '0)),
    .raddr (IW'(depth_r - DW'(1))),
    .rdata (rd_data)
  );

  always_comb begin
    depth_nxt = depth_r;
    if (push) begin
      depth_nxt = depth_r + DW'(1);
    end else if (is_ret && (depth_r != '0)) begin
      depth_nxt = depth_r - DW'(1);
    end
  end

  assign depth_ext = {{DEPTH_W{1'b0}}, depth_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (is_call || busy_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_start_r <= CODE_START_RST;
      code_end_r   <= CODE_END_RST;
      depth_r      <= '0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CODE_START: code_start_r <= cfg_wdata;
          REG_CODE_END:   code_end_r   <= cfg_wdata;
          default:        code_start_r <= code_start_r;
        endcase
      end
      depth_r     <= depth_nxt;
      busy_r      <= is_ret;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_ret) begin
      ret_addr_r <= in_ret_addr[AW-1:0];
      empty_r    <= (depth_r == '0);
    end
    if (is_call || busy_r) begin
      out_status_r <= verdict.status;
      out_cause_r  <= verdict.cause;
      out_full_r   <= call_full;
      out_depth_r  <= depth_ext[DEPTH_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_cause      = out_cause_r;
  assign out_stack_full = out_full_r;
  assign out_depth      = out_depth_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= FULL_DEPTH)
    else $error("stack depth above capacity");

  a_ret_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !out_valid_r)
    else $error("return result would overwrite a held beat");

  a_full_keeps_depth: assert property (@(posedge clk) disable iff (!rst_n)
    call_full |=> depth_r == $past(depth_r))
    else $error("depth changed on dropped push");

  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(is_call || busy_r))
    else $error("result beat without an item");

  a_ret_follows: assert property (@(posedge clk) disable iff (!rst_n)
    is_ret |=> busy_r && out_valid_nxt)
    else $error("return result not produced on the next cycle");

endmodule

FILE: bench/scs_event_checker.sv
module scs_event_checker #(
  parameter int STACK_DEPTH = scs_pkg::DEF_STACK_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_action,
  input  logic [scs_pkg::ADDR_W-1:0]  in_target_addr,
  input  logic [scs_pkg::ADDR_W-1:0]  in_ret_addr,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [1:0]                  out_status,
  input  logic [1:0]                  out_cause,
  input  logic                        out_stack_full,
  input  logic [scs_pkg::DEPTH_W-1:0] out_depth,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [scs_pkg::ADDR_W-1:0]  cfg_wdata,
  output int                          mismatches,
  output int                          pending
);

  import scs_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         cause;
    logic               full;
    logic [DEPTH_W-1:0] depth;
  } event_verdict_t;

  logic [ADDR_W-1:0] region_lo;
  logic [ADDR_W-1:0] region_hi;
  logic [ADDR_W-1:0] return_sites [STACK_DEPTH];
  int                site_count;
  int                beats_seen;
  event_verdict_t    expected_verdicts [$];
  event_verdict_t    want;
  event_verdict_t    got;

  initial begin
    mismatches = 0;
    pending    = 0;
    beats_seen = 0;
    site_count = 0;
    region_lo  = CODE_START_RST;
    region_hi  = CODE_END_RST;
  end

  function automatic bit in_code(input logic [ADDR_W-1:0] addr);
    return (addr >= region_lo) && (addr <= region_hi);
  endfunction

  // judges each event and updates the shadow copy of the stack as the block would
  function automatic event_verdict_t judge_event(input logic act,
                                                 input logic [ADDR_W-1:0] tgt,
                                                 input logic [ADDR_W-1:0] ra);
    event_verdict_t    v;
    logic [ADDR_W-1:0] popped;
    v.status = ST_VALID;
    v.cause  = CA_NONE;
    v.full   = 1'b0;
    popped   = '0;
    if (act == ACT_CALL) begin
      if (!in_code(tgt)) begin
        v.status = ST_BAD_CALL;
        v.cause  = CA_REGION;
      end else if ((tgt[1:0] & ALIGN_MASK) != 2'b00) begin
        v.status = ST_BAD_CALL;
        v.cause  = CA_UNALIGNED;
      end else if (site_count < STACK_DEPTH) begin
        return_sites[site_count] = ra;
        site_count++;
      end else begin
        v.full = 1'b1;
      end
    end else begin
      if (site_count > 0) begin
        site_count--;
        popped = return_sites[site_count];
      end
      // zero popped means nothing to match against
      if (!in_code(ra)) begin
        v.status = ST_BAD_RET;
        v.cause  = CA_REGION;
      end else if (popped != '0 && ra != popped) begin
        v.status = ST_BAD_RET;
        v.cause  = CA_MISMATCH;
      end else if ((ra[1:0] & ALIGN_MASK) != 2'b00) begin
        v.status = ST_BAD_RET;
        v.cause  = CA_UNALIGNED;
      end
    end
    v.depth = site_count[DEPTH_W-1:0];
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      site_count = 0;
      region_lo  = CODE_START_RST;
      region_hi  = CODE_END_RST;
      expected_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_status, out_cause, out_stack_full, out_depth};
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d unexpected: status/cause/full/depth %0d/%0d/%0d/%0d",
                     beats_seen, got.status, got.cause, got.full, got.depth);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.status != want.status || got.cause != want.cause ||
              got.full != want.full || got.depth != want.depth) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d status/cause/full/depth: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       beats_seen, want.status, want.cause, want.full, want.depth,
                       got.status, got.cause, got.full, got.depth);
          end
        end
        beats_seen++;
      end
      if (in_valid && !in_stall)
        expected_verdicts.push_back(judge_event(in_action, in_target_addr, in_ret_addr));
      // register write lands at this edge, after any beat taken here
      if (cfg_we) begin
        if (cfg_index == REG_CODE_START)
          region_lo = cfg_wdata;
        else
          region_hi = cfg_wdata;
      end
    end
    pending = expected_verdicts.size();
  end

endmodule

FILE: bench/shadow_call_stack_checker_top_tb.sv
module shadow_call_stack_checker_top_tb;
  import scs_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_HALF  = 35;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic               in_action      = ACT_CALL;
  logic [ADDR_W-1:0]  in_target_addr = '0;
  logic [ADDR_W-1:0]  in_ret_addr    = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [1:0]         out_status;
  logic [1:0]         out_cause;
  logic               out_stack_full;
  logic [DEPTH_W-1:0] out_depth;
  logic               cfg_we         = 1'b0;
  logic               cfg_index      = REG_CODE_START;
  logic [ADDR_W-1:0]  cfg_wdata      = '0;

  int                mismatches;
  int                pending;
  int                cycle_count    = 0;
  int                send_idle_pct  = 0;
  int                recv_idle_pct  = 0;
  logic [ADDR_W-1:0] cur_lo         = CODE_START_RST;
  logic [ADDR_W-1:0] cur_hi         = CODE_END_RST;
  logic [ADDR_W-1:0] open_sites [$];

  shadow_call_stack_checker_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_target_addr (in_target_addr),
    .in_ret_addr    (in_ret_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_cause      (out_cause),
    .out_stack_full (out_stack_full),
    .out_depth      (out_depth),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  scs_event_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_target_addr (in_target_addr),
    .in_ret_addr    (in_ret_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_cause      (out_cause),
    .out_stack_full (out_stack_full),
    .out_depth      (out_depth),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // tracks return sites only to shape well-formed call/return nesting
  task automatic send_event(input logic act, input logic [ADDR_W-1:0] tgt,
                            input logic [ADDR_W-1:0] ra);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_target_addr <= tgt;
    in_ret_addr    <= ra;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_CALL) begin
      if (tgt >= cur_lo && tgt <= cur_hi && tgt[1:0] == 2'b00 &&
          open_sites.size() < DEF_STACK_DEPTH)
        open_sites.push_back(ra);
    end else if (open_sites.size() > 0) begin
      void'(open_sites.pop_back());
    end
    @(negedge clk);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CODE_START)
      cur_lo = val;
    else
      cur_hi = val;
    @(negedge clk);
  endtask

  task automatic set_region(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    drain_all();
    write_reg(REG_CODE_START, lo);
    write_reg(REG_CODE_END, hi);
  endtask

  function automatic logic [ADDR_W-1:0] pick_code_addr();
    logic [ADDR_W-1:0] a;
    if (cur_lo > cur_hi)
      return $urandom;
    a = $urandom_range(cur_hi, cur_lo);
    a[1:0] = 2'b00;
    if (a < cur_lo)
      a = a + 4;
    return a;
  endfunction

  task automatic good_call();
    logic [ADDR_W-1:0] ra;
    ra = ($urandom_range(15) == 0) ? '0 : pick_code_addr();
    send_event(ACT_CALL, pick_code_addr(), ra);
  endtask

  task automatic good_return();
    logic [ADDR_W-1:0] ra;
    ra = (open_sites.size() > 0) ? open_sites[$] : pick_code_addr();
    send_event(ACT_RET, $urandom, ra);
  endtask

  task automatic random_event();
    int                pick;
    logic [ADDR_W-1:0] ra;
    pick = $urandom_range(99);
    if (pick < 45) begin
      good_call();
    end else if (pick < 80) begin
      good_return();
    end else if (pick < 90) begin
      // broken return: unaligned, wrong site or outside the region
      case ($urandom_range(2))
        0: ra = pick_code_addr() | $urandom_range(3, 1);
        1: ra = pick_code_addr();
        default: ra = $urandom;
      endcase
      send_event(ACT_RET, $urandom, ra);
    end else if (pick < 95) begin
      send_event(ACT_CALL, pick_code_addr() | $urandom_range(3, 1), $urandom);
    end else begin
      send_event(1'($urandom_range(1)), $urandom, $urandom);
    end
  endtask

  // overfills the stack, then unwinds past empty
  task automatic deep_nest();
    repeat (DEF_STACK_DEPTH + 2) good_call();
    repeat (DEF_STACK_DEPTH + 2) good_return();
  endtask

  task automatic random_phase(input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (RANDOM_HALF) begin
      random_event();
      if ($urandom_range(49) == 0)
        drain_all();
    end
    deep_nest();
    repeat (RANDOM_HALF) random_event();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 30;
    // reset region 0x100000..0x800000, empty stack
    send_event(ACT_RET, $urandom, 32'h0010_0000);
    send_event(ACT_RET, $urandom, 32'h0010_0002);
    send_event(ACT_RET, $urandom, 32'h0000_0000);
    send_event(ACT_RET, $urandom, 32'hFFFF_FFFF);
    send_event(ACT_CALL, 32'h0010_0000, 32'h0010_0010);
    send_event(ACT_CALL, 32'h0080_0000, 32'h0000_0000);
    // zero site popped: no mismatch check
    send_event(ACT_RET, $urandom, 32'h007F_FFFC);
    send_event(ACT_CALL, 32'h000F_FFFC, $urandom);
    send_event(ACT_CALL, 32'h0080_0004, $urandom);
    send_event(ACT_CALL, 32'h0010_0001, $urandom);
    send_event(ACT_CALL, 32'h0010_0002, $urandom);
    send_event(ACT_CALL, 32'hFFFF_FFFF, $urandom);
    send_event(ACT_CALL, 32'h0000_0000, 32'hFFFF_FFFF);
    // mismatch wins over misalignment
    send_event(ACT_RET, $urandom, 32'h0010_0012);
    send_event(ACT_CALL, 32'h0040_0000, 32'h0040_0004);
    send_event(ACT_RET, $urandom, 32'h0040_0004);

    // empty region
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_region(32'h0000_8000, 32'h0000_7FFC);
    send_event(ACT_CALL, 32'h0000_8000, 32'h0000_8000);
    send_event(ACT_RET, $urandom, 32'h0000_8000);
    send_event(ACT_CALL, 32'h0000_7FFC, 32'h0000_7FFC);
    // single-address region
    set_region(32'h0000_4000, 32'h0000_4000);
    send_event(ACT_CALL, 32'h0000_4000, 32'h0000_4000);
    send_event(ACT_CALL, 32'h0000_4004, 32'h0000_4000);
    send_event(ACT_RET, $urandom, 32'h0000_4000);
    send_event(ACT_RET, $urandom, 32'h0000_4000);

    set_region(32'h0000_0000, 32'hFFFF_FFFF);
    random_phase(6, 51);
    set_region(32'h0000_1000, 32'h0000_FFFF);
    random_phase(51, 6);
    set_region(32'hFFFF_0000, 32'hFFFF_FFFF);
    random_phase(0, 0);

    drain_all();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/scs_pkg.sv
sv/scs_ram.sv
sv/scs_check.sv
sv/shadow_call_stack_checker_top.sv
bench/scs_event_checker.sv
bench/shadow_call_stack_checker_top_tb.sv
